/* rtl/arp_icmp_echo_responder_macros.svh */
// Assertion macros for the ARP and ICMP echo responder.
// Expects signals clk and rst_n in the scope of each use.
`ifndef ARP_ICMP_ECHO_RESPONDER_MACROS_SVH
`define ARP_ICMP_ECHO_RESPONDER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AIER_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define AIER_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/aier_pkg.sv */
// Package for the ARP and ICMP echo responder: beat types, sequencer types,
// protocol constants and the one's complement add. No dependencies.
package aier_pkg;

    // Index width covering every kept word count and every reply word index.
    localparam int IDX_W = 7;

    localparam logic [15:0] ETH_ARP    = 16'h0806;
    localparam logic [15:0] ETH_IPV4   = 16'h0800;
    localparam logic [15:0] ARP_HTYPE  = 16'h0001;
    localparam logic [15:0] ARP_PROTO_IP = 16'h0800;
    localparam logic [15:0] ARP_HLPL   = 16'h0604;
    localparam logic [15:0] ARP_OP_REQ = 16'h0001;
    localparam logic [15:0] ARP_OP_REP = 16'h0002;
    localparam logic [7:0]  PROTO_ICMP = 8'h01;
    localparam logic [15:0] IP_VER_IHL = 16'h4500;
    localparam logic [15:0] IP_TTL_PROTO = 16'h8001;
    localparam int          ARP_BYTES  = 42;
    localparam int          ARP_WORDS  = 21;

    localparam logic CFG_OWN_MAC = 1'b0;
    localparam logic CFG_OWN_IP  = 1'b1;

    localparam logic KIND_ARP  = 1'b0;
    localparam logic KIND_ICMP = 1'b1;

    typedef struct packed {
        logic [15:0] frame_word;
        logic        word_last;
        logic        broadcast_hit;
        logic        unicast_hit;
    } frame_t;

    typedef struct packed {
        logic [15:0] reply_word;
        logic        reply_last;
        logic        reply_kind;
        logic [6:0]  reply_bytes;
    } reply_t;

    typedef enum logic [2:0] {
        ST_RECV,
        ST_SCAN,
        ST_CALC,
        ST_DECIDE,
        ST_EMIT
    } state_t;

    // Sequencer status towards the datapath.
    typedef struct packed {
        state_t           state;
        logic             scan_v;
        logic [IDX_W-1:0] scan_idx;
        logic [3:0]       calc_step;
        logic [IDX_W-1:0] emit_idx;
        logic             rd_en;
        logic [IDX_W-1:0] rd_idx;
        logic             kind;
        logic             done;
    } seq_t;

    // Verdict of the datapath, taken in the decision step.
    typedef struct packed {
        logic go;
        logic kind;
    } decide_t;

    // One's complement 16-bit add with end-around carry.
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'b0, s[16]};
    endfunction

endpackage

/* rtl/aier_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module aier_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 37
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/aier_csum.sv */
// Shared one's complement accumulator used for every checksum.
// Depends on aier_pkg.
module aier_csum
    import aier_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        clear,
    input  logic        add_en,
    input  logic [15:0] term,
    output logic [15:0] acc
);

    logic [15:0] acc_reg;
    logic [15:0] acc_next;

    // Clear wins over an add in the same cycle.
    always_comb
    begin
        acc_next = acc_reg;
        if (clear)
        begin
            acc_next = '0;
        end
        else if (add_en)
        begin
            acc_next = ones_add(acc_reg, term);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

/* rtl/aier_seq.sv */
// Sequencer: scan of the kept words, reply checksum steps, decision and emit.
// Depends on aier_pkg.
module aier_seq
    import aier_pkg::*;
#(
    parameter int ICMP_PAYLOAD_BYTES = 32
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    frame_end,
    input  decide_t verdict,
    output seq_t    seq
);

    localparam int PAY_WORDS  = (ICMP_PAYLOAD_BYTES + 1) / 2;
    localparam int SCAN_FIRST = 3;
    localparam int SCAN_LAST  = 20 + PAY_WORDS;
    localparam int CALC_LAST  = 9;
    localparam int ICMP_WORDS = ARP_WORDS + PAY_WORDS;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic             scan_v_reg, scan_v_next;
    logic [IDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic [3:0]       calc_step_reg, calc_step_next;
    logic [IDX_W-1:0] emit_idx_reg, emit_idx_next;
    logic             kind_reg, kind_next;
    logic             scan_rd;
    logic [IDX_W-1:0] emit_end;

    assign scan_rd  = (rd_idx_reg <= IDX_W'(SCAN_LAST));
    assign emit_end = (kind_reg == KIND_ICMP) ? IDX_W'(ICMP_WORDS - 1) : IDX_W'(ARP_WORDS - 1);

    // Next state and counters.
    always_comb
    begin
        state_next     = state_reg;
        rd_idx_next    = rd_idx_reg;
        scan_v_next    = 1'b0;
        scan_idx_next  = scan_idx_reg;
        calc_step_next = calc_step_reg;
        emit_idx_next  = emit_idx_reg;
        kind_next      = kind_reg;
        case (state_reg)
            ST_RECV:
            begin
                if (frame_end)
                begin
                    state_next  = ST_SCAN;
                    rd_idx_next = IDX_W'(SCAN_FIRST);
                end
            end
            ST_SCAN:
            begin
                if (scan_rd)
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                scan_v_next   = scan_rd;
                scan_idx_next = rd_idx_reg;
                if (scan_v_reg && scan_idx_reg == IDX_W'(SCAN_LAST))
                begin
                    state_next     = ST_CALC;
                    scan_v_next    = 1'b0;
                    calc_step_next = '0;
                end
            end
            ST_CALC:
            begin
                calc_step_next = calc_step_reg + 1'b1;
                if (calc_step_reg == 4'(CALC_LAST))
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                emit_idx_next = '0;
                kind_next     = verdict.kind;
                state_next    = verdict.go ? ST_EMIT : ST_RECV;
            end
            ST_EMIT:
            begin
                emit_idx_next = emit_idx_reg + 1'b1;
                if (emit_idx_reg == emit_end)
                begin
                    state_next = ST_RECV;
                end
            end
            default:
            begin
                state_next = ST_RECV;
            end
        endcase
    end

    // Outputs towards the datapath and the store.
    always_comb
    begin
        seq.state     = state_reg;
        seq.scan_v    = scan_v_reg;
        seq.scan_idx  = scan_idx_reg;
        seq.calc_step = calc_step_reg;
        seq.emit_idx  = emit_idx_reg;
        seq.kind      = kind_reg;
        seq.rd_en     = 1'b0;
        seq.rd_idx    = rd_idx_reg;
        seq.done      = 1'b0;
        case (state_reg)
            ST_SCAN:
            begin
                seq.rd_en = scan_rd;
            end
            ST_DECIDE:
            begin
                seq.done = !verdict.go;
            end
            ST_EMIT:
            begin
                seq.rd_en  = 1'b1;
                seq.rd_idx = emit_idx_reg + 1'b1;
                seq.done   = (emit_idx_reg == emit_end);
            end
            default:
            begin
                seq.rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RECV;
            rd_idx_reg    <= '0;
            scan_v_reg    <= 1'b0;
            scan_idx_reg  <= '0;
            calc_step_reg <= '0;
            emit_idx_reg  <= '0;
            kind_reg      <= KIND_ARP;
        end
        else
        begin
            state_reg     <= state_next;
            rd_idx_reg    <= rd_idx_next;
            scan_v_reg    <= scan_v_next;
            scan_idx_reg  <= scan_idx_next;
            calc_step_reg <= calc_step_next;
            emit_idx_reg  <= emit_idx_next;
            kind_reg      <= kind_next;
        end
    end

endmodule

/* rtl/arp_icmp_echo_responder.sv */
// Top level of the ARP and ICMP echo responder: frame store, header capture,
// decision and reply word selection. Depends on aier_pkg, aier_ram, aier_csum,
// aier_seq and arp_icmp_echo_responder_macros.svh.
//
//  Channel  | Handshake           | Payload
//  ---------+---------------------+--------------------------------
//  frame    | start high, busy low| frame_t (word, last, hit flags)
//  reply    | strobe, no stall    | reply_t (word, last, kind, bytes)
//  config   | cfg_we              | cfg_index, cfg_data
//
// A word that is not the last of its frame leaves busy low.
// After the last word busy stays high for the scan of the store through the
// shared checksum adder (reads of words 3 to 20 + PW plus the read latency, PW
// being the payload words), ten checksum steps, the decision step and the
// reply beats: 21 for ARP, 21 + PW for ICMP, one per cycle. Reset clears the
// control state and the fill count; the store itself is never cleared.
`include "arp_icmp_echo_responder_macros.svh"

module arp_icmp_echo_responder
    import aier_pkg::*;
#(
    parameter int ICMP_PAYLOAD_BYTES = 32,
    parameter int KEPT_FRAME_WORDS   = 37
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  frame_t      frame,
    output logic        strobe,
    output reply_t      reply,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [47:0] cfg_data
);

    localparam int PAY_WORDS = (ICMP_PAYLOAD_BYTES + 1) / 2;
    localparam int ODD_IDX   = 20 + PAY_WORDS;
    localparam bit PAY_ODD   = (ICMP_PAYLOAD_BYTES % 2) != 0;
    localparam int AW        = $clog2(KEPT_FRAME_WORDS);
    localparam int HDR_LO    = 3;
    localparam int HDR_HI    = 20;

    logic [47:0]      own_mac_reg;
    logic [31:0]      own_ip_reg;
    logic [IDX_W-1:0] count_reg;
    logic [1:0]       flags_reg;
    logic [15:0]      hdr_reg [HDR_LO:HDR_HI];
    logic [15:0]      ip_sum_reg;
    logic [15:0]      icmp_sum_reg;

    logic             accept;
    logic             frame_end;
    logic             store_wr;
    logic [15:0]      ram_q;
    logic [15:0]      scan_data;
    logic [15:0]      emit_data;
    logic             csum_clear;
    logic             csum_add;
    logic [15:0]      csum_term;
    logic [15:0]      acc;
    logic [15:0]      ip_hi;
    logic [15:0]      ip_lo;
    logic [15:0]      ver_term;
    logic             arp_ok;
    logic             icmp_ok;
    seq_t             seq;
    decide_t          verdict;

    assign accept    = start && !busy;
    assign frame_end = accept && frame.word_last;
    assign store_wr  = accept && (count_reg < IDX_W'(KEPT_FRAME_WORDS));
    assign busy      = (seq.state != ST_RECV);
    assign ip_hi     = own_ip_reg[31:16];
    assign ip_lo     = own_ip_reg[15:0];
    assign ver_term  = IP_VER_IHL | {8'h00, hdr_reg[7][7:0]};

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_mac_reg <= '0;
            own_ip_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_OWN_MAC: own_mac_reg <= cfg_data;
                CFG_OWN_IP:  own_ip_reg  <= cfg_data[31:0];
                default:     own_ip_reg  <= own_ip_reg;
            endcase
        end
    end

    // Fill count and the hit flags of the latest beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            flags_reg <= '0;
        end
        else
        begin
            if (store_wr)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (seq.done)
            begin
                count_reg <= '0;
            end
            if (accept)
            begin
                flags_reg <= {frame.unicast_hit, frame.broadcast_hit};
            end
        end
    end

    aier_ram #(
        .WIDTH (16),
        .DEPTH (KEPT_FRAME_WORDS)
    ) u_store (
        .clk     (clk),
        .wr_en   (store_wr),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (frame.frame_word),
        .rd_en   (seq.rd_en),
        .rd_addr (seq.rd_idx[AW-1:0]),
        .rd_data (ram_q)
    );

    // Words not received read as zero; the odd payload byte keeps its upper half.
    always_comb
    begin
        scan_data = (seq.scan_idx < count_reg) ? ram_q : 16'h0000;
        if (PAY_ODD && seq.scan_idx == IDX_W'(ODD_IDX))
        begin
            scan_data = scan_data & 16'hff00;
        end
        emit_data = (seq.emit_idx < count_reg) ? ram_q : 16'h0000;
        if (PAY_ODD && seq.emit_idx == IDX_W'(ODD_IDX))
        begin
            emit_data = emit_data & 16'hff00;
        end
    end

    // Header capture during the scan.
    always_ff @(posedge clk)
    begin
        for (int g = HDR_LO; g <= HDR_HI; g++)
        begin
            if (seq.scan_v && seq.scan_idx == IDX_W'(g))
            begin
                hdr_reg[g] <= scan_data;
            end
        end
    end

    // Terms for the shared adder: received IP header, ICMP part, reply IP header.
    always_comb
    begin
        csum_clear = frame_end;
        csum_add   = 1'b0;
        csum_term  = scan_data;
        if (seq.state == ST_SCAN && seq.scan_v)
        begin
            if (seq.scan_idx == 7'd17)
            begin
                csum_clear = 1'b1;
            end
            csum_add = (seq.scan_idx >= 7'd7 && seq.scan_idx <= 7'd16 && seq.scan_idx != 7'd12)
                || (seq.scan_idx >= 7'd19);
        end
        else if (seq.state == ST_CALC)
        begin
            csum_add = 1'b1;
            case (seq.calc_step)
                4'd0:    begin csum_clear = 1'b1; csum_add = 1'b0; end
                4'd1:    csum_term = ver_term;
                4'd2:    csum_term = 16'(28 + ICMP_PAYLOAD_BYTES);
                4'd3:    csum_term = hdr_reg[9];
                4'd4:    csum_term = hdr_reg[10];
                4'd5:    csum_term = IP_TTL_PROTO;
                4'd6:    csum_term = ip_hi;
                4'd7:    csum_term = ip_lo;
                4'd8:    csum_term = hdr_reg[13];
                4'd9:    csum_term = hdr_reg[14];
                default: csum_add = 1'b0;
            endcase
        end
    end

    aier_csum u_csum (
        .clk    (clk),
        .rst_n  (rst_n),
        .clear  (csum_clear),
        .add_en (csum_add),
        .term   (csum_term),
        .acc    (acc)
    );

    // Partial sums saved before the accumulator is reused.
    always_ff @(posedge clk)
    begin
        if (seq.state == ST_SCAN && seq.scan_v && seq.scan_idx == 7'd17)
        begin
            ip_sum_reg <= acc;
        end
        if (seq.state == ST_CALC && seq.calc_step == 4'd0)
        begin
            icmp_sum_reg <= acc;
        end
    end

    // Decision on the captured header.
    always_comb
    begin
        arp_ok = (hdr_reg[6] == ETH_ARP) && (flags_reg[0] || flags_reg[1])
            && (hdr_reg[19] == ip_hi) && (hdr_reg[20] == ip_lo)
            && (hdr_reg[10] == ARP_OP_REQ);
        icmp_ok = !flags_reg[0] && flags_reg[1] && (hdr_reg[6] == ETH_IPV4)
            && (~ip_sum_reg == hdr_reg[12])
            && (hdr_reg[15] == ip_hi) && (hdr_reg[16] == ip_lo)
            && (hdr_reg[11][7:0] == PROTO_ICMP);
        verdict.go   = arp_ok || icmp_ok;
        verdict.kind = (hdr_reg[6] == ETH_ARP) ? KIND_ARP : KIND_ICMP;
    end

    aier_seq #(
        .ICMP_PAYLOAD_BYTES (ICMP_PAYLOAD_BYTES)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .frame_end (frame_end),
        .verdict   (verdict),
        .seq       (seq)
    );

    // Reply beat selection.
    always_comb
    begin
        strobe            = (seq.state == ST_EMIT);
        reply.reply_kind  = seq.kind;
        reply.reply_last  = seq.done && strobe;
        reply.reply_bytes = (seq.kind == KIND_ICMP) ? 7'(ARP_BYTES + ICMP_PAYLOAD_BYTES)
                                                    : 7'(ARP_BYTES);
        reply.reply_word  = emit_data;
        case (seq.emit_idx)
            7'd0:  reply.reply_word = hdr_reg[3];
            7'd1:  reply.reply_word = hdr_reg[4];
            7'd2:  reply.reply_word = hdr_reg[5];
            7'd3:  reply.reply_word = own_mac_reg[47:32];
            7'd4:  reply.reply_word = own_mac_reg[31:16];
            7'd5:  reply.reply_word = own_mac_reg[15:0];
            7'd6:  reply.reply_word = hdr_reg[6];
            default:
            begin
                if (seq.kind == KIND_ARP)
                begin
                    case (seq.emit_idx)
                        7'd7:    reply.reply_word = ARP_HTYPE;
                        7'd8:    reply.reply_word = ARP_PROTO_IP;
                        7'd9:    reply.reply_word = ARP_HLPL;
                        7'd10:   reply.reply_word = ARP_OP_REP;
                        7'd11:   reply.reply_word = own_mac_reg[47:32];
                        7'd12:   reply.reply_word = own_mac_reg[31:16];
                        7'd13:   reply.reply_word = own_mac_reg[15:0];
                        7'd14:   reply.reply_word = ip_hi;
                        7'd15:   reply.reply_word = ip_lo;
                        7'd16:   reply.reply_word = hdr_reg[11];
                        7'd17:   reply.reply_word = hdr_reg[12];
                        7'd18:   reply.reply_word = hdr_reg[13];
                        7'd19:   reply.reply_word = hdr_reg[14];
                        7'd20:   reply.reply_word = hdr_reg[15];
                        default: reply.reply_word = emit_data;
                    endcase
                end
                else
                begin
                    case (seq.emit_idx)
                        7'd7:    reply.reply_word = ver_term;
                        7'd8:    reply.reply_word = 16'(28 + ICMP_PAYLOAD_BYTES);
                        7'd9:    reply.reply_word = hdr_reg[9];
                        7'd10:   reply.reply_word = hdr_reg[10];
                        7'd11:   reply.reply_word = IP_TTL_PROTO;
                        7'd12:   reply.reply_word = ~acc;
                        7'd13:   reply.reply_word = ip_hi;
                        7'd14:   reply.reply_word = ip_lo;
                        7'd15:   reply.reply_word = hdr_reg[13];
                        7'd16:   reply.reply_word = hdr_reg[14];
                        7'd17:   reply.reply_word = 16'h0000;
                        7'd18:   reply.reply_word = ~icmp_sum_reg;
                        7'd19:   reply.reply_word = hdr_reg[19];
                        7'd20:   reply.reply_word = hdr_reg[20];
                        default: reply.reply_word = emit_data;
                    endcase
                end
            end
        endcase
    end

    // Checks on the reply sequencing and on busy after a word that is not the last.
    `AIER_ASSERT_NOW(a_strobe_busy, strobe, busy, "reply beat while not busy")
    `AIER_ASSERT_NEXT(a_last_ends, strobe && reply.reply_last, !strobe, "beat after last")
    `AIER_ASSERT_NEXT(a_no_gap, strobe && !reply.reply_last, strobe, "gap inside reply")
    `AIER_ASSERT_NEXT(a_mid_word, accept && !frame.word_last, !busy, "busy after mid word")

endmodule

/* dv/arp_icmp_echo_responder_test.sv */
// Self-checking testbench for arp_icmp_echo_responder: drives received frames
// word by word, predicts ARP and ICMP echo replies and checks every reply beat.
// Depends on aier_pkg and the responder RTL.
`timescale 1ns / 1ps

module arp_icmp_echo_responder_test;
    import aier_pkg::*;

    localparam int PAYLOAD_BYTES = 32;
    localparam int KEPT_WORDS    = 37;
    localparam int PAYLOAD_WORDS = (PAYLOAD_BYTES + 1) / 2;
    localparam int SETTLE_CYCLES = 100;
    localparam int STALL_LIMIT   = 4000;
    localparam int RANDOM_BEATS  = 225;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    frame_t      frame;
    logic        strobe;
    reply_t      reply;
    logic        cfg_we;
    logic        cfg_index;
    logic [47:0] cfg_data;

    arp_icmp_echo_responder #(
        .ICMP_PAYLOAD_BYTES(PAYLOAD_BYTES),
        .KEPT_FRAME_WORDS  (KEPT_WORDS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .frame    (frame),
        .strobe   (strobe),
        .reply    (reply),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Predictor state: its own copy of the registers and the frame store.
    logic [47:0] mac_shadow;
    logic [31:0] ip_shadow;
    logic [15:0] kept_words [KEPT_WORDS];
    int          kept_count;
    reply_t      pending_replies [$];

    int errors;
    int beats_sent;
    int arp_replies;
    int echo_replies;
    int dropped_frames;
    int sender_idle_pct;
    int quiet_cycles;

    function automatic logic [15:0] kept(input int i);
        if (i < kept_count && i < KEPT_WORDS)
            return kept_words[i];
        return 16'h0000;
    endfunction

    // Fold a wide sum to 16 bits with end-around carry and invert it.
    function automatic logic [15:0] fold_sum(input logic [31:0] s);
        while (s[31:16] != 16'h0000)
            s = {16'h0000, s[15:0]} + {16'h0000, s[31:16]};
        return ~s[15:0];
    endfunction

    task automatic queue_reply(input logic [15:0] words [], input logic kind,
                               input logic [6:0] total);
        reply_t r;
        for (int k = 0; k < words.size(); k++)
        begin
            r.reply_word  = words[k];
            r.reply_last  = (k == words.size() - 1);
            r.reply_kind  = kind;
            r.reply_bytes = total;
            pending_replies.push_back(r);
        end
    endtask

    // Decide the reply for a completed frame and queue its beats.
    task automatic build_reply();
        logic [15:0] r [];
        logic [15:0] ip_hi;
        logic [15:0] ip_lo;
        logic [31:0] acc;
        logic        bc;
        logic        uc;
        logic [15:0] proto_word;
        logic [15:0] ver_word;
        ip_hi = ip_shadow[31:16];
        ip_lo = ip_shadow[15:0];
        bc    = frame.broadcast_hit;
        uc    = frame.unicast_hit;
        proto_word = kept(11);
        ver_word   = kept(7);
        if (kept(6) == ETH_ARP && (bc || uc))
        begin
            if (kept(19) != ip_hi || kept(20) != ip_lo || kept(10) != ARP_OP_REQ)
            begin
                dropped_frames++;
                return;
            end
            r = new[ARP_WORDS];
            r[0] = kept(3); r[1] = kept(4); r[2] = kept(5);
            r[3] = mac_shadow[47:32]; r[4] = mac_shadow[31:16]; r[5] = mac_shadow[15:0];
            r[6] = ETH_ARP; r[7] = ARP_HTYPE; r[8] = ARP_PROTO_IP; r[9] = ARP_HLPL;
            r[10] = ARP_OP_REP;
            r[11] = r[3]; r[12] = r[4]; r[13] = r[5];
            r[14] = ip_hi; r[15] = ip_lo;
            for (int i = 0; i < 5; i++)
                r[16 + i] = kept(11 + i);
            queue_reply(r, KIND_ARP, 7'(ARP_BYTES));
            arp_replies++;
            return;
        end
        if (!bc && uc && kept(6) == ETH_IPV4)
        begin
            acc = 0;
            for (int i = 0; i < 10; i++)
                if (i != 5)
                    acc += kept(7 + i);
            if (fold_sum(acc) != kept(12) || kept(15) != ip_hi || kept(16) != ip_lo
                || proto_word[7:0] != PROTO_ICMP)
            begin
                dropped_frames++;
                return;
            end
            r = new[ARP_WORDS + PAYLOAD_WORDS];
            r[0] = kept(3); r[1] = kept(4); r[2] = kept(5);
            r[3] = mac_shadow[47:32]; r[4] = mac_shadow[31:16]; r[5] = mac_shadow[15:0];
            r[6] = ETH_IPV4;
            r[7] = IP_VER_IHL | {8'h00, ver_word[7:0]};
            r[8] = 16'(28 + PAYLOAD_BYTES);
            r[9] = kept(9); r[10] = kept(10);
            r[11] = IP_TTL_PROTO; r[12] = 16'h0000;
            r[13] = ip_hi; r[14] = ip_lo; r[15] = kept(13); r[16] = kept(14);
            acc = 0;
            for (int i = 7; i < 17; i++)
                acc += r[i];
            r[12] = fold_sum(acc);
            r[17] = 16'h0000; r[18] = 16'h0000;
            r[19] = kept(19); r[20] = kept(20);
            for (int i = 0; i < PAYLOAD_WORDS; i++)
                r[21 + i] = kept(21 + i);
            if (PAYLOAD_BYTES % 2 != 0)
                r[20 + PAYLOAD_WORDS] = r[20 + PAYLOAD_WORDS] & 16'hff00;
            acc = 0;
            for (int i = 17; i < 21 + PAYLOAD_WORDS; i++)
                acc += r[i];
            r[18] = fold_sum(acc);
            queue_reply(r, KIND_ICMP, 7'(ARP_BYTES + PAYLOAD_BYTES));
            echo_replies++;
            return;
        end
        dropped_frames++;
    endtask

    // Update the predictor with an accepted beat; frame holds that beat.
    task automatic predict_beat(input logic keep_reply);
        int depth;
        depth = pending_replies.size();
        if (kept_count < KEPT_WORDS)
        begin
            kept_words[kept_count] = frame.frame_word;
            kept_count++;
        end
        if (frame.word_last)
        begin
            build_reply();
            kept_count = 0;
            // Rows with a typed-in drop discard whatever the predictor made.
            while (!keep_reply && pending_replies.size() > depth)
                void'(pending_replies.pop_back());
        end
    endtask

    // Offer one beat, idling at random first, and wait until it is taken.
    task automatic send_beat(input frame_t f, input logic keep_reply);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        frame <= f;
        do
            @(posedge clk);
        while (busy);
        predict_beat(keep_reply);
        beats_sent++;
    endtask

    // Wait until every reply has arrived and the block has settled.
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending_replies.size() != 0 || busy)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [47:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_OWN_MAC)
            mac_shadow = value;
        else
            ip_shadow = value[31:0];
    endtask

    task automatic set_address(input logic [47:0] mac, input logic [31:0] ip);
        write_reg(CFG_OWN_MAC, mac);
        write_reg(CFG_OWN_IP, {16'h0000, ip});
    endtask

    // Send one random frame: mostly well-formed requests with random content,
    // some with a bit flipped, some pure noise.
    task automatic send_random_frame();
        logic [15:0] w [];
        logic [31:0] acc;
        int          choice;
        int          len;
        logic        bc;
        logic        uc;
        frame_t      f;
        choice = $urandom_range(9);
        if (choice < 4)
            len = $urandom_range(21, 30);
        else if (choice < 8)
            len = ($urandom_range(4) == 0) ? $urandom_range(17, 36) : $urandom_range(37, 50);
        else
            len = $urandom_range(1, 45);
        w = new[len];
        foreach (w[i])
            w[i] = 16'($urandom);
        bc = $urandom_range(1);
        uc = $urandom_range(1);
        if (choice < 4)
        begin
            w[6] = ETH_ARP; w[10] = ARP_OP_REQ;
            w[19] = ip_shadow[31:16]; w[20] = ip_shadow[15:0];
            if ($urandom_range(5) != 0 && !bc && !uc)
                bc = 1'b1;
        end
        else if (choice < 8)
        begin
            w[6] = ETH_IPV4;
            w[11][7:0] = PROTO_ICMP;
            if (len > 16)
            begin
                w[15] = ip_shadow[31:16];
                w[16] = ip_shadow[15:0];
            end
            acc = 0;
            for (int i = 7; i < 17; i++)
                if (i != 12 && i < len)
                    acc += w[i];
            if (len > 12)
                w[12] = fold_sum(acc);
            if ($urandom_range(5) != 0)
            begin
                bc = 1'b0;
                uc = 1'b1;
            end
        end
        // Broken sequences: one flipped bit somewhere in the frame, good or noise.
        if (choice == 9 || (choice < 8 && $urandom_range(7) == 0))
        begin
            len = $urandom_range(0, w.size() - 1);
            w[len][$urandom_range(15)] ^= 1'b1;
        end
        foreach (w[i])
        begin
            f.frame_word    = w[i];
            f.word_last     = (i == w.size() - 1);
            f.broadcast_hit = f.word_last ? bc : 1'($urandom);
            f.unicast_hit   = f.word_last ? uc : 1'($urandom);
            send_beat(f, 1'b1);
        end
    endtask

    task automatic random_phase(input int beats);
        int target;
        target = beats_sent + beats;
        while (beats_sent < target)
            send_random_frame();
    endtask

    // Reply checker: every strobe beat must match the oldest expectation.
    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n && strobe)
        begin
            if (pending_replies.size() == 0)
            begin
                $display("%0t: reply beat expected none actual %h", $time, reply);
                errors++;
            end
            else
            begin
                want = pending_replies.pop_front();
                if (reply.reply_word !== want.reply_word)
                begin
                    $display("%0t: reply_word expected %h actual %h",
                             $time, want.reply_word, reply.reply_word);
                    errors++;
                end
                if (reply.reply_last !== want.reply_last)
                begin
                    $display("%0t: reply_last expected %b actual %b",
                             $time, want.reply_last, reply.reply_last);
                    errors++;
                end
                if (reply.reply_kind !== want.reply_kind)
                begin
                    $display("%0t: reply_kind expected %b actual %b",
                             $time, want.reply_kind, reply.reply_kind);
                    errors++;
                end
                if (reply.reply_bytes !== want.reply_bytes)
                begin
                    $display("%0t: reply_bytes expected %0d actual %0d",
                             $time, want.reply_bytes, reply.reply_bytes);
                    errors++;
                end
            end
        end
    end

    // Watchdog: too long without an accepted beat, a reply beat or a register write ends the run.
    always @(posedge clk)
    begin
        if ((start && !busy) || strobe || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    // Directed frames: a lone final word, a broadcast ARP request for the
    // block's own address, and a two-word frame of all ones and all zeros.
    typedef struct {
        frame_t beat;
        logic   keep;
    } stim_row_t;

    stim_row_t directed [$];

    task automatic add_row(input logic [15:0] w, input logic last, input logic bc,
                           input logic uc, input logic keep);
        stim_row_t row;
        row.beat = '{frame_word: w, word_last: last, broadcast_hit: bc, unicast_hit: uc};
        row.keep = keep;
        directed.push_back(row);
    endtask

    initial
    begin
        logic [15:0] arp_req [21];
        errors          = 0;
        beats_sent      = 0;
        arp_replies     = 0;
        echo_replies    = 0;
        dropped_frames  = 0;
        quiet_cycles    = 0;
        kept_count      = 0;
        mac_shadow      = '0;
        ip_shadow       = '0;
        sender_idle_pct = 28;
        rst_n     = 1'b0;
        start     = 1'b0;
        frame     = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_OWN_MAC;
        cfg_data  = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_address(48'h02_1a_2b_3c_4d_5e, 32'hc0a8_0107);

        arp_req = '{16'hffff, 16'hffff, 16'hffff, 16'h0011, 16'h2233, 16'h4455,
                    ETH_ARP, ARP_HTYPE, ARP_PROTO_IP, ARP_HLPL, ARP_OP_REQ,
                    16'h0011, 16'h2233, 16'h4455, 16'hc0a8, 16'h0101,
                    16'h0000, 16'h0000, 16'h0000, 16'hc0a8, 16'h0107};
        // A single final word with no flags: dropped.
        add_row(16'h0000, 1'b1, 1'b0, 1'b0, 1'b0);
        foreach (arp_req[i])
            add_row(arp_req[i], i == 20, 1'b1, 1'b0, 1'b1);
        // All-ones then all-zeros word with both flags: no EtherType, dropped.
        add_row(16'hffff, 1'b0, 1'b1, 1'b1, 1'b0);
        add_row(16'h0000, 1'b1, 1'b1, 1'b1, 1'b0);
        foreach (directed[i])
            send_beat(directed[i].beat, directed[i].keep);
        drain();

        random_phase(RANDOM_BEATS / 3);
        drain();

        // Extreme addresses: all ones, then all zeros.
        set_address('1, '1);
        sender_idle_pct = 52;
        random_phase(RANDOM_BEATS / 3);
        drain();

        set_address('0, '0);
        sender_idle_pct = 0;
        random_phase(RANDOM_BEATS / 3);
        drain();

        $display("Sent %0d frame words over three address settings and idle rates.",
                 beats_sent);
        $display("Replies: %0d ARP, %0d ICMP echo; %0d frames dropped.",
                 arp_replies, echo_replies, dropped_frames);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
